FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SHM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle is followed by another in the next cycle.
`define SHM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/shm_pkg.sv
`default_nettype none

package shm_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int TIMEOUT_W      = 31;
  localparam int MV_W           = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 31;

  localparam logic [TIMEOUT_W-1:0] IMU_TIMEOUT_RST = 31'd100000;
  localparam logic [TIMEOUT_W-1:0] GPS_TIMEOUT_RST = 31'd2000000;
  localparam logic [MV_W-1:0]      BATT_MIN_RST    = 16'd5000;
  localparam logic [MV_W-1:0]      BATT_MAX_RST    = 16'd20000;

  localparam logic [7:0]  IMU_QUAL_BAD      = 8'd0;
  localparam logic [7:0]  IMU_QUAL_DEGRADED = 8'd1;
  localparam logic [7:0]  GPS_SATS_GOOD     = 8'd8;
  localparam logic [15:0] GPS_HDOP_GOOD     = 16'd150;
  localparam logic [7:0]  GPS_SATS_FAIR     = 8'd6;
  localparam logic [15:0] GPS_HDOP_FAIR     = 16'd250;
  localparam logic [7:0]  GPS_SATS_MIN      = 8'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMU_TIMEOUT = 2'd0,
    CFG_GPS_TIMEOUT = 2'd1,
    CFG_BATT_MIN    = 2'd2,
    CFG_BATT_MAX    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    GRADE_OK       = 2'd0,
    GRADE_DEGRADED = 2'd1,
    GRADE_ERROR    = 2'd2
  } grade_e;

  typedef struct packed {
    logic            battery_low;
    logic [MV_W-1:0] battery_mv;
    logic            link_up;
    logic            motor_ready;
    logic            gps_fresh;
    logic [15:0]     gps_hdop;
    logic [7:0]      gps_sats;
    logic            gps_ready;
    logic            imu_fresh;
    logic [7:0]      imu_quality;
    logic            imu_ready;
  } sensor_t;

  typedef struct packed {
    logic imu;
    logic gps;
  } stale_t;

  typedef struct packed {
    logic [2:0] error_total;
    grade_e     battery_grade;
    grade_e     link_grade;
    grade_e     motor_grade;
    grade_e     gps_grade;
    grade_e     imu_grade;
  } result_t;

  localparam int SENSOR_W = $bits(sensor_t);
  localparam int RESULT_W = $bits(result_t);
  localparam int OUT_W    = ((RESULT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

FILE: rtl/shm_tracker.sv
`default_nettype none

module shm_tracker #(
  parameter int TimeWidth = shm_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           take_i,
  input  wire logic [TimeWidth-1:0]           now_i,
  input  wire logic                           imu_ready_i,
  input  wire logic                           imu_fresh_i,
  input  wire logic                           gps_ready_i,
  input  wire logic                           gps_fresh_i,
  input  wire logic [shm_pkg::TIMEOUT_W-1:0]  imu_timeout_i,
  input  wire logic [shm_pkg::TIMEOUT_W-1:0]  gps_timeout_i,
  output shm_pkg::stale_t                     stale_o
);
  import shm_pkg::*;

  localparam int CmpW = (TimeWidth > TIMEOUT_W) ? TimeWidth : TIMEOUT_W;

  logic                 primed_q;
  logic [TimeWidth-1:0] imu_last_q, imu_last_d, gps_last_q, gps_last_d;
  logic                 imu_pend_q, imu_pend_d, gps_pend_q, gps_pend_d;
  logic [TimeWidth-1:0] imu_base, gps_base, imu_diff, gps_diff;
  logic                 imu_pend, gps_pend, imu_hit, gps_hit;

  always_comb begin
    imu_base   = primed_q ? imu_last_q : now_i;
    gps_base   = primed_q ? gps_last_q : now_i;
    imu_pend   = imu_pend_q | imu_fresh_i;
    gps_pend   = gps_pend_q | gps_fresh_i;
    imu_hit    = imu_ready_i & imu_pend;
    gps_hit    = gps_ready_i & gps_pend;
    imu_last_d = imu_hit ? now_i : imu_base;
    gps_last_d = gps_hit ? now_i : gps_base;
    imu_pend_d = imu_pend & ~imu_hit;
    gps_pend_d = gps_pend & ~gps_hit;
    imu_diff   = now_i - imu_last_d;
    gps_diff   = now_i - gps_last_d;
    stale_o.imu = imu_ready_i && (CmpW'(imu_diff) > CmpW'(imu_timeout_i));
    stale_o.gps = gps_ready_i && (CmpW'(gps_diff) > CmpW'(gps_timeout_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q   <= 1'b0;
      imu_last_q <= '0;
      gps_last_q <= '0;
      imu_pend_q <= 1'b0;
      gps_pend_q <= 1'b0;
    end else if (take_i) begin
      primed_q   <= 1'b1;
      imu_last_q <= imu_last_d;
      gps_last_q <= gps_last_d;
      imu_pend_q <= imu_pend_d;
      gps_pend_q <= gps_pend_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/shm_grader.sv
`default_nettype none

module shm_grader (
  input  wire shm_pkg::sensor_t           sensor_i,
  input  wire shm_pkg::stale_t            stale_i,
  input  wire logic [shm_pkg::MV_W-1:0]   batt_min_i,
  input  wire logic [shm_pkg::MV_W-1:0]   batt_max_i,
  output shm_pkg::result_t                result_o
);
  import shm_pkg::*;

  grade_e imu_g, gps_g, motor_g, link_g, batt_g;

  always_comb begin
    if (!sensor_i.imu_ready || stale_i.imu) begin
      imu_g = GRADE_ERROR;
    end else if (sensor_i.imu_quality == IMU_QUAL_BAD) begin
      imu_g = GRADE_ERROR;
    end else if (sensor_i.imu_quality == IMU_QUAL_DEGRADED) begin
      imu_g = GRADE_DEGRADED;
    end else begin
      imu_g = GRADE_OK;
    end

    if (!sensor_i.gps_ready) begin
      gps_g = (sensor_i.gps_sats != '0) ? GRADE_DEGRADED : GRADE_ERROR;
    end else if (stale_i.gps) begin
      gps_g = GRADE_ERROR;
    end else if ((sensor_i.gps_sats >= GPS_SATS_GOOD && sensor_i.gps_hdop < GPS_HDOP_GOOD) ||
                 (sensor_i.gps_sats >= GPS_SATS_FAIR && sensor_i.gps_hdop < GPS_HDOP_FAIR)) begin
      gps_g = GRADE_OK;
    end else if (sensor_i.gps_sats >= GPS_SATS_MIN) begin
      gps_g = GRADE_DEGRADED;
    end else begin
      gps_g = GRADE_ERROR;
    end

    motor_g = sensor_i.motor_ready ? GRADE_OK : GRADE_ERROR;
    link_g  = sensor_i.link_up ? GRADE_OK : GRADE_ERROR;

    if (sensor_i.battery_mv < batt_min_i || sensor_i.battery_mv > batt_max_i) begin
      batt_g = GRADE_ERROR;
    end else if (sensor_i.battery_low) begin
      batt_g = GRADE_DEGRADED;
    end else begin
      batt_g = GRADE_OK;
    end

    result_o.imu_grade     = imu_g;
    result_o.gps_grade     = gps_g;
    result_o.motor_grade   = motor_g;
    result_o.link_grade    = link_g;
    result_o.battery_grade = batt_g;
    result_o.error_total   = 3'({2'b0, imu_g == GRADE_ERROR} + {2'b0, gps_g == GRADE_ERROR} +
                                {2'b0, motor_g == GRADE_ERROR} + {2'b0, link_g == GRADE_ERROR} +
                                {2'b0, batt_g == GRADE_ERROR});
  end

endmodule

`default_nettype wire

FILE: rtl/subsystem_health_monitor_top.sv
`default_nettype none
`include "assert_macros.svh"

// Subsystem health monitor. Each input word is one health check; each check
// yields exactly one result word with the IMU, GPS, motor, link and battery
// grades (0 ok, 1 degraded, 2 error) and the count of errors. The block takes
// one word per cycle while the master side is not stalled. A check waits in
// the input register, where grading and the timestamp tracking run, and moves
// into the result register as it advances, where its result word is valid.
// A stalled master side holds both registers and backs up the slave side.
// The first check primes both timestamps.
// Write the configuration registers only while no check is in flight.
module subsystem_health_monitor_top #(
  parameter int TimeWidth = shm_pkg::TIME_WIDTH_DEF,
  localparam int InW      = ((TimeWidth + shm_pkg::SENSOR_W + 7) / 8) * 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [shm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [shm_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // now_us, imu_ready, imu_quality, imu_fresh, gps_ready, gps_sats, gps_hdop,
  // gps_fresh, motor_ready, link_up, battery_mv, battery_low, zero fill
  input  wire logic [InW-1:0]                  s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // imu_grade, gps_grade, motor_grade, link_grade, battery_grade, error_total,
  // zero fill
  output logic [shm_pkg::OUT_W-1:0]            m_axis_tdata
);
  import shm_pkg::*;

  logic [TIMEOUT_W-1:0] imu_timeout_q, gps_timeout_q;
  logic [MV_W-1:0]      batt_min_q, batt_max_q;

  logic                 s0_valid_q, s0_valid_d;
  logic [TimeWidth-1:0] s0_now_q;
  sensor_t              s0_sensor_q;
  logic                 out_valid_q, out_valid_d;
  result_t              out_result_q, result_d;
  stale_t               stale;
  logic                 in_fire, advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      imu_timeout_q <= IMU_TIMEOUT_RST;
      gps_timeout_q <= GPS_TIMEOUT_RST;
      batt_min_q    <= BATT_MIN_RST;
      batt_max_q    <= BATT_MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_IMU_TIMEOUT: imu_timeout_q <= cfg_wdata_i[TIMEOUT_W-1:0];
        CFG_GPS_TIMEOUT: gps_timeout_q <= cfg_wdata_i[TIMEOUT_W-1:0];
        CFG_BATT_MIN:    batt_min_q    <= cfg_wdata_i[MV_W-1:0];
        CFG_BATT_MAX:    batt_max_q    <= cfg_wdata_i[MV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign advance       = s0_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s0_valid_q || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    s0_valid_d  = in_fire ? 1'b1 : (advance ? 1'b0 : s0_valid_q);
    out_valid_d = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s0_valid_q  <= s0_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s0_now_q    <= s_axis_tdata[TimeWidth-1:0];
      s0_sensor_q <= s_axis_tdata[TimeWidth +: SENSOR_W];
    end
    if (advance) begin
      out_result_q <= result_d;
    end
  end

  shm_tracker #(
    .TimeWidth(TimeWidth)
  ) u_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (advance),
    .now_i        (s0_now_q),
    .imu_ready_i  (s0_sensor_q.imu_ready),
    .imu_fresh_i  (s0_sensor_q.imu_fresh),
    .gps_ready_i  (s0_sensor_q.gps_ready),
    .gps_fresh_i  (s0_sensor_q.gps_fresh),
    .imu_timeout_i(imu_timeout_q),
    .gps_timeout_i(gps_timeout_q),
    .stale_o      (stale)
  );

  shm_grader u_grader (
    .sensor_i  (s0_sensor_q),
    .stale_i   (stale),
    .batt_min_i(batt_min_q),
    .batt_max_i(batt_max_q),
    .result_o  (result_d)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_W - RESULT_W){1'b0}}, out_result_q};

  `SHM_ASSERT_NEXT(a_s0_hold, s0_valid_q && !advance,
                   s0_valid_q && $stable(s0_now_q) && $stable(s0_sensor_q),
                   "stalled check lost or changed in input register")
  `SHM_ASSERT_NEXT(a_result_loaded, advance, m_axis_tvalid,
                   "graded check did not reach result register")
  `SHM_ASSERT(a_error_count, !out_valid_q || (out_result_q.error_total == 3'($countones({
              out_result_q.imu_grade == GRADE_ERROR, out_result_q.gps_grade == GRADE_ERROR,
              out_result_q.motor_grade == GRADE_ERROR, out_result_q.link_grade == GRADE_ERROR,
              out_result_q.battery_grade == GRADE_ERROR}))),
              "error total does not match error grades")

endmodule

`default_nettype wire
